// ===== sv/arhdr_pkg.sv =====
package arhdr_pkg;

  localparam int NAME_SLOTS = 16;
  localparam int RAM_DEPTH  = 2 * NAME_SLOTS;
  localparam int RAM_AW     = $clog2(RAM_DEPTH);
  localparam int OUT_TDATA_W = 168;

  localparam logic [5:0]  LAST_POS      = 6'd59;
  localparam logic [5:0]  MAGIC_POS     = 6'd58;
  localparam logic [7:0]  MAGIC_FIRST   = 8'h60;
  localparam logic [7:0]  MAGIC_SECOND  = 8'h0A;
  localparam logic [7:0]  CH_HASH       = 8'h23;
  localparam logic [7:0]  CH_ONE        = 8'h31;
  localparam logic [7:0]  CH_SLASH      = 8'h2F;
  localparam logic [7:0]  CH_SPACE      = 8'h20;
  localparam logic [7:0]  CH_NUL        = 8'h00;
  localparam logic [7:0]  CH_ZERO       = 8'h30;
  localparam logic [7:0]  CH_SEVEN      = 8'h37;
  localparam logic [7:0]  CH_NINE       = 8'h39;
  localparam logic [16:0] EXT_SAT       = 17'h1FFFF;
  localparam logic [23:0] REG_FILE_BIT  = 24'o0100000;
  localparam logic [15:0] MAX_NAME_RST  = 16'd1024;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
  localparam logic [1:0] ST_NAME_LONG = 2'd2;
  localparam logic [1:0] ST_NAME_SIZE = 2'd3;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_CHAR    = 1'b1;

  // field_stopped flag bits
  localparam int FS_TIME = 0;
  localparam int FS_UID  = 1;
  localparam int FS_GID  = 2;
  localparam int FS_MODE = 3;
  localparam int FS_SIZE = 4;
  localparam int FS_EXT  = 5;

  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } name_wr_t;

  typedef struct packed {
    logic        bank;
    logic [4:0]  nchars;
    logic [1:0]  status;
    logic [39:0] mod_time;
    logic [19:0] owner_id;
    logic [19:0] group_id;
    logic [23:0] file_mode;
    logic [33:0] data_size;
    logic        pad_byte;
    logic        extended_name;
    logic [15:0] name_length;
    logic        last;
  } summary_t;

  typedef struct packed {
    logic        item_kind;
    logic [1:0]  status;
    logic [39:0] mod_time;
    logic [19:0] owner_id;
    logic [19:0] group_id;
    logic [23:0] file_mode;
    logic [33:0] data_size;
    logic        pad_byte;
    logic        extended_name;
    logic [15:0] name_length;
    logic [7:0]  name_char;
    logic        last;
  } item_t;

endpackage

// ===== sv/arhdr_ram.sv =====
module arhdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/arhdr_parse.sv =====
module arhdr_parse import arhdr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_start,
  input  logic [7:0]  in_byte,
  input  logic [15:0] max_name_len,
  input  logic        emit_ready,
  output logic        in_take,
  output name_wr_t    name_wr,
  output logic        sum_valid,
  output summary_t    sum
);

  logic [5:0]  pos;
  logic [39:0] time_acc;
  logic [19:0] uid_acc;
  logic [19:0] gid_acc;
  logic [23:0] mode_acc;
  logic [33:0] size_acc;
  logic [16:0] ext_acc;
  logic [5:0]  stopped;
  logic [4:0]  short_len;
  logic [2:0]  marker;
  logic        magic_ok;
  logic        wbank;

  // header_start clears state before the byte is taken
  logic [5:0]  pos_e;
  logic [39:0] time_e;
  logic [19:0] uid_e;
  logic [19:0] gid_e;
  logic [23:0] mode_e;
  logic [33:0] size_e;
  logic [16:0] ext_e;
  logic [5:0]  stopped_e;
  logic [4:0]  short_len_e;
  logic [2:0]  marker_e;
  logic        magic_e;

  logic [39:0] time_next;
  logic [19:0] uid_next;
  logic [19:0] gid_next;
  logic [23:0] mode_next;
  logic [33:0] size_next;
  logic [16:0] ext_next;
  logic [5:0]  stopped_next;
  logic [4:0]  short_len_next;
  logic [2:0]  marker_next;
  logic        magic_next;

  logic        is_dec;
  logic        is_oct;
  logic [3:0]  dig;
  logic [20:0] ext_sum;
  logic        finish;
  logic        bad_magic;
  logic        is_ext;
  logic        too_long;
  logic        over_size;

  always_comb begin
    pos_e       = in_start ? 6'd0   : pos;
    time_e      = in_start ? 40'd0  : time_acc;
    uid_e       = in_start ? 20'd0  : uid_acc;
    gid_e       = in_start ? 20'd0  : gid_acc;
    mode_e      = in_start ? 24'd0  : mode_acc;
    size_e      = in_start ? 34'd0  : size_acc;
    ext_e       = in_start ? 17'd0  : ext_acc;
    stopped_e   = in_start ? 6'd0   : stopped;
    short_len_e = in_start ? 5'd0   : short_len;
    marker_e    = in_start ? 3'd0   : marker;
    magic_e     = in_start ? 1'b0   : magic_ok;

    is_dec = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    is_oct = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);
    dig    = in_byte[3:0];

    finish  = (pos_e == LAST_POS);
    in_take = in_valid && !(finish && !emit_ready);

    time_next      = time_e;
    uid_next       = uid_e;
    gid_next       = gid_e;
    mode_next      = mode_e;
    size_next      = size_e;
    ext_next       = ext_e;
    stopped_next   = stopped_e;
    short_len_next = short_len_e;
    marker_next    = marker_e;
    magic_next     = magic_e;
    ext_sum        = {1'b0, ext_e, 3'b000} + {3'b000, ext_e, 1'b0} + {17'd0, dig};

    name_wr.en   = 1'b0;
    name_wr.addr = {wbank, pos_e[3:0]};
    name_wr.data = in_byte;

    if (pos_e < 6'd16) begin
      if (short_len_e == {1'b0, pos_e[3:0]} && in_byte != CH_SPACE &&
          in_byte != CH_SLASH && in_byte != CH_NUL) begin
        name_wr.en     = in_take;
        short_len_next = short_len_e + 5'd1;
      end
      if (pos_e == 6'd0 && in_byte == CH_HASH)  marker_next[0] = 1'b1;
      if (pos_e == 6'd1 && in_byte == CH_ONE)   marker_next[1] = 1'b1;
      if (pos_e == 6'd2 && in_byte == CH_SLASH) marker_next[2] = 1'b1;
      if (pos_e >= 6'd3 && !stopped_e[FS_EXT]) begin
        if (is_dec) begin
          ext_next = (ext_sum > {4'd0, EXT_SAT}) ? EXT_SAT : ext_sum[16:0];
        end else begin
          stopped_next[FS_EXT] = 1'b1;
        end
      end
    end else if (pos_e < 6'd28) begin
      if (!stopped_e[FS_TIME]) begin
        if (is_dec) time_next = {time_e[36:0], 3'b000} + {time_e[38:0], 1'b0} + {36'd0, dig};
        else        stopped_next[FS_TIME] = 1'b1;
      end
    end else if (pos_e < 6'd34) begin
      if (!stopped_e[FS_UID]) begin
        if (is_dec) uid_next = {uid_e[16:0], 3'b000} + {uid_e[18:0], 1'b0} + {16'd0, dig};
        else        stopped_next[FS_UID] = 1'b1;
      end
    end else if (pos_e < 6'd40) begin
      if (!stopped_e[FS_GID]) begin
        if (is_dec) gid_next = {gid_e[16:0], 3'b000} + {gid_e[18:0], 1'b0} + {16'd0, dig};
        else        stopped_next[FS_GID] = 1'b1;
      end
    end else if (pos_e < 6'd48) begin
      if (!stopped_e[FS_MODE]) begin
        if (is_oct) mode_next = {mode_e[20:0], dig[2:0]};
        else        stopped_next[FS_MODE] = 1'b1;
      end
    end else if (pos_e < 6'd58) begin
      if (!stopped_e[FS_SIZE]) begin
        if (is_dec) size_next = {size_e[30:0], 3'b000} + {size_e[32:0], 1'b0} + {30'd0, dig};
        else        stopped_next[FS_SIZE] = 1'b1;
      end
    end else if (pos_e == MAGIC_POS) begin
      magic_next = (in_byte == MAGIC_FIRST);
    end

    bad_magic = !(magic_e && in_byte == MAGIC_SECOND);
    is_ext    = (marker_e == 3'b111);
    too_long  = is_ext && (ext_e > {1'b0, max_name_len});
    over_size = ({17'd0, ext_e} > size_e);

    sum_valid         = in_take && finish;
    sum.bank          = wbank;
    sum.nchars        = 5'd0;
    sum.status        = ST_OK;
    sum.mod_time      = time_e;
    sum.owner_id      = uid_e;
    sum.group_id      = gid_e;
    sum.file_mode     = mode_e | REG_FILE_BIT;
    sum.data_size     = size_e;
    sum.pad_byte      = size_e[0];
    sum.extended_name = 1'b0;
    sum.name_length   = {11'd0, short_len_e};
    sum.last          = 1'b1;
    if (bad_magic || too_long) begin
      sum        = '0;
      sum.bank   = wbank;
      sum.status = bad_magic ? ST_BAD_MAGIC : ST_NAME_LONG;
      sum.last   = 1'b1;
    end else if (is_ext) begin
      sum.extended_name = 1'b1;
      sum.name_length   = ext_e[15:0];
      if (over_size) begin
        sum.status    = ST_NAME_SIZE;
        sum.data_size = 34'd0;
      end else begin
        sum.data_size = size_e - {17'd0, ext_e};
      end
    end else begin
      sum.nchars = short_len_e;
      sum.last   = (short_len_e == 5'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      time_acc  <= '0;
      uid_acc   <= '0;
      gid_acc   <= '0;
      mode_acc  <= '0;
      size_acc  <= '0;
      ext_acc   <= '0;
      stopped   <= '0;
      short_len <= '0;
      marker    <= '0;
      magic_ok  <= 1'b0;
      wbank     <= 1'b0;
    end else if (in_take) begin
      if (finish) begin
        // header done: clear and move name writes to the other bank
        pos       <= '0;
        time_acc  <= '0;
        uid_acc   <= '0;
        gid_acc   <= '0;
        mode_acc  <= '0;
        size_acc  <= '0;
        ext_acc   <= '0;
        stopped   <= '0;
        short_len <= '0;
        marker    <= '0;
        magic_ok  <= 1'b0;
        wbank     <= !wbank;
      end else begin
        pos       <= pos_e + 6'd1;
        time_acc  <= time_next;
        uid_acc   <= uid_next;
        gid_acc   <= gid_next;
        mode_acc  <= mode_next;
        size_acc  <= size_next;
        ext_acc   <= ext_next;
        stopped   <= stopped_next;
        short_len <= short_len_next;
        marker    <= marker_next;
        magic_ok  <= magic_next;
      end
    end
  end

endmodule

// ===== sv/arhdr_emit.sv =====
module arhdr_emit import arhdr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              sum_valid,
  input  summary_t          sum,
  output logic              emit_ready,
  output logic [RAM_AW-1:0] rd_addr,
  input  logic [7:0]        rd_data,
  output logic              out_valid,
  input  logic              out_ready,
  output item_t             out_item
);

  summary_t   sum_q;
  logic       busy;
  logic       sum_pend;
  logic       fetched;
  logic [3:0] idx;
  logic       out_free;
  logic       load_sum;
  logic       load_char;
  logic       char_last;
  item_t      sum_item;
  item_t      char_item;

  assign emit_ready = !busy;
  assign rd_addr    = {sum_q.bank, idx};
  assign out_free   = !out_valid || out_ready;
  assign load_sum   = busy && sum_pend && out_free;
  assign load_char  = busy && !sum_pend && fetched && out_free;
  assign char_last  = ({1'b0, idx} + 5'd1 == sum_q.nchars);

  always_comb begin
    sum_item               = '0;
    sum_item.item_kind     = KIND_SUMMARY;
    sum_item.status        = sum_q.status;
    sum_item.mod_time      = sum_q.mod_time;
    sum_item.owner_id      = sum_q.owner_id;
    sum_item.group_id      = sum_q.group_id;
    sum_item.file_mode     = sum_q.file_mode;
    sum_item.data_size     = sum_q.data_size;
    sum_item.pad_byte      = sum_q.pad_byte;
    sum_item.extended_name = sum_q.extended_name;
    sum_item.name_length   = sum_q.name_length;
    sum_item.last          = sum_q.last;

    char_item           = '0;
    char_item.item_kind = KIND_CHAR;
    char_item.name_char = rd_data;
    char_item.last      = char_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      sum_pend  <= 1'b0;
      fetched   <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (sum_valid && !busy) begin
        busy     <= 1'b1;
        sum_pend <= 1'b1;
      end
      if (load_sum) begin
        sum_pend  <= 1'b0;
        idx       <= '0;
        fetched   <= 1'b0;
        out_valid <= 1'b1;
        if (sum_q.nchars == 5'd0) busy <= 1'b0;
      end else if (load_char) begin
        idx       <= idx + 4'd1;
        fetched   <= 1'b0;
        out_valid <= 1'b1;
        if (char_last) busy <= 1'b0;
      end else begin
        // read address held since the last load: RAM data is now valid
        fetched <= 1'b1;
        if (out_ready) out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid && !busy) begin
      sum_q <= sum;
    end
    if (load_sum) begin
      out_item <= sum_item;
    end else if (load_char) begin
      out_item <= char_item;
    end
  end

endmodule

// ===== sv/ar_archive_header_parser_core.sv =====
// Path: after the header's last byte is accepted, the summary item passes the input byte,
// summary and output registers; each short-name character is loaded once its name-store
// read data is valid. Throughput: one input byte per cycle; the input stalls only if a
// header ends while the previous header's items are being sent (name store read port).
// Reset (rst, synchronous): byte position to 0, all parse state cleared,
// max_name_length to 1024, both channels empty.
module ar_archive_header_parser_core import arhdr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] data_byte
  input  logic                   s_axis_tuser,   // header_start
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [1:0] status, [41:2] mod_time, [61:42] owner_id, [81:62] group_id,
  // [105:82] file_mode, [139:106] data_size, [140] pad_byte, [141] extended_name,
  // [157:142] name_length, [165:158] name_char, [167:166] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tuser,   // item_kind
  output logic                   m_axis_tlast,   // last
  input  logic                   cfg_wr_en,
  input  logic [15:0]            cfg_wr_data
);

  logic              in_valid;
  logic              in_start;
  logic [7:0]        in_byte;
  logic [15:0]       max_name_len;
  logic              in_take;
  logic              emit_ready;
  logic              sum_valid;
  summary_t          sum;
  name_wr_t          name_wr;
  logic [RAM_AW-1:0] rd_addr;
  logic [7:0]        rd_data;
  item_t             out_item;

  assign s_axis_tready = !in_valid || in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      max_name_len <= MAX_NAME_RST;
    end else begin
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (cfg_wr_en) max_name_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_start <= s_axis_tuser;
      in_byte  <= s_axis_tdata;
    end
  end

  arhdr_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_start     (in_start),
    .in_byte      (in_byte),
    .max_name_len (max_name_len),
    .emit_ready   (emit_ready),
    .in_take      (in_take),
    .name_wr      (name_wr),
    .sum_valid    (sum_valid),
    .sum          (sum)
  );

  arhdr_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_name_ram (
    .clk     (clk),
    .wr_en   (name_wr.en),
    .wr_addr (name_wr.addr),
    .wr_data (name_wr.data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  arhdr_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .sum_valid  (sum_valid),
    .sum        (sum),
    .emit_ready (emit_ready),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_item   (out_item)
  );

  assign m_axis_tuser = out_item.item_kind;
  assign m_axis_tlast = out_item.last;
  assign m_axis_tdata = {2'b00, out_item.name_char, out_item.name_length,
                         out_item.extended_name, out_item.pad_byte, out_item.data_size,
                         out_item.file_mode, out_item.group_id, out_item.owner_id,
                         out_item.mod_time, out_item.status};

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import arhdr_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NCASES = 5;

  typedef logic [7:0] hdr_bytes_t [60];

  typedef struct {
    int         limit;     // name limit written before the header, -1 for none
    logic       hs;        // header_start on byte 0
    int         cut;       // bytes sent, 60 for a whole header
    string      nm, mt, ui, gi, md, sz;
    int         ovr_pos;   // byte replaced after the text is laid out, -1 for none
    logic [7:0] ovr_val;
    logic       typed;     // single summary given below instead of the parser's
    item_t      want;
  } hdr_case_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  ar_archive_header_parser_core DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // header parse state, mirrored from the block
  logic [5:0]  hpos;
  logic [39:0] acc_time;
  logic [19:0] acc_uid, acc_gid;
  logic [23:0] acc_mode;
  logic [33:0] acc_size;
  logic [16:0] acc_ext;
  logic [5:0]  stopped;
  logic [7:0]  short_chars [16];
  logic [4:0]  short_len;
  logic [2:0]  marker;
  logic        magic_hi_ok;
  logic [15:0] name_limit;

  item_t pending [$];
  hdr_case_t cases [NCASES];
  int errs = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;
  bit no_gaps = 1'b0;

  function automatic void clear_parse();
    hpos = '0;
    acc_time = '0;
    acc_uid = '0;
    acc_gid = '0;
    acc_mode = '0;
    acc_size = '0;
    acc_ext = '0;
    stopped = '0;
    short_len = '0;
    marker = '0;
    magic_hi_ok = 1'b0;
  endfunction

  // a numeric field ends for good at its first non-digit
  function automatic bit take_digit(input int fld, input logic [7:0] b,
                                    input logic [7:0] top, output logic [3:0] d);
    d = '0;
    if (stopped[fld]) return 1'b0;
    if (b < CH_ZERO || b > top) begin
      stopped[fld] = 1'b1;
      return 1'b0;
    end
    d = 4'(b - CH_ZERO);
    return 1'b1;
  endfunction

  // advance the parse by one byte; queue the header's results after its last byte
  function automatic int parse_byte(input logic hs, input logic [7:0] b);
    logic [3:0] d;
    logic [31:0] t;
    item_t r;
    logic ext;
    int n, k;
    n = 0;
    if (hs) clear_parse();
    if (hpos < 6'd16) begin
      if ({1'b0, short_len} == hpos && b != CH_SPACE && b != CH_SLASH && b != CH_NUL) begin
        short_chars[hpos[3:0]] = b;
        short_len = short_len + 5'd1;
      end
      if (hpos == 6'd0 && b == CH_HASH) marker[0] = 1'b1;
      if (hpos == 6'd1 && b == CH_ONE) marker[1] = 1'b1;
      if (hpos == 6'd2 && b == CH_SLASH) marker[2] = 1'b1;
      if (hpos >= 6'd3 && take_digit(FS_EXT, b, CH_NINE, d)) begin
        t = 32'(acc_ext) * 32'd10 + 32'(d);
        acc_ext = (t > 32'(EXT_SAT)) ? EXT_SAT : t[16:0];
      end
    end else if (hpos < 6'd28) begin
      if (take_digit(FS_TIME, b, CH_NINE, d)) acc_time = acc_time * 40'd10 + 40'(d);
    end else if (hpos < 6'd34) begin
      if (take_digit(FS_UID, b, CH_NINE, d)) acc_uid = acc_uid * 20'd10 + 20'(d);
    end else if (hpos < 6'd40) begin
      if (take_digit(FS_GID, b, CH_NINE, d)) acc_gid = acc_gid * 20'd10 + 20'(d);
    end else if (hpos < 6'd48) begin
      if (take_digit(FS_MODE, b, CH_SEVEN, d)) acc_mode = {acc_mode[20:0], d[2:0]};
    end else if (hpos < MAGIC_POS) begin
      if (take_digit(FS_SIZE, b, CH_NINE, d)) acc_size = acc_size * 34'd10 + 34'(d);
    end else if (hpos == MAGIC_POS) begin
      magic_hi_ok = (b == MAGIC_FIRST);
    end
    if (hpos < LAST_POS) begin
      hpos = hpos + 6'd1;
      return 0;
    end

    r = '0;
    r.item_kind = KIND_SUMMARY;
    r.last = 1'b1;
    ext = (marker == 3'b111);
    if (!(magic_hi_ok && b == MAGIC_SECOND)) begin
      r.status = ST_BAD_MAGIC;
      pending.push_back(r);
      n = 1;
    end else if (ext && acc_ext > {1'b0, name_limit}) begin
      r.status = ST_NAME_LONG;
      pending.push_back(r);
      n = 1;
    end else begin
      r.mod_time = acc_time;
      r.owner_id = acc_uid;
      r.group_id = acc_gid;
      r.file_mode = acc_mode | REG_FILE_BIT;
      r.pad_byte = acc_size[0];
      if (ext) begin
        r.extended_name = 1'b1;
        r.name_length = acc_ext[15:0];
        if (34'(acc_ext) > acc_size) begin
          r.status = ST_NAME_SIZE;
          r.data_size = '0;
        end else begin
          r.data_size = acc_size - 34'(acc_ext);
        end
        pending.push_back(r);
        n = 1;
      end else begin
        r.data_size = acc_size;
        r.name_length = 16'(short_len);
        r.last = (short_len == 5'd0);
        pending.push_back(r);
        n = 1;
        for (k = 0; k < int'(short_len); k++) begin
          r = '0;
          r.item_kind = KIND_CHAR;
          r.name_char = short_chars[k];
          r.last = (k + 1 == int'(short_len));
          pending.push_back(r);
          n++;
        end
      end
    end
    clear_parse();
    return n;
  endfunction

  function automatic item_t summary_of(input logic [1:0] st, input logic [39:0] mt,
                                       input logic [19:0] ui, input logic [19:0] gi,
                                       input logic [23:0] md, input logic [33:0] sz,
                                       input logic pad, input logic ext,
                                       input logic [15:0] nl);
    item_t r;
    r = '0;
    r.item_kind = KIND_SUMMARY;
    r.status = st;
    r.mod_time = mt;
    r.owner_id = ui;
    r.group_id = gi;
    r.file_mode = md;
    r.data_size = sz;
    r.pad_byte = pad;
    r.extended_name = ext;
    r.name_length = nl;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void put_text(inout hdr_bytes_t h, input int at, input int width,
                                   input string s);
    int k;
    for (k = 0; k < width; k++) h[at + k] = (k < s.len()) ? 8'(s[k]) : CH_SPACE;
  endfunction

  function automatic void text_header(input hdr_case_t c, output hdr_bytes_t h);
    foreach (h[k]) h[k] = CH_SPACE;
    put_text(h, 0, 16, c.nm);
    put_text(h, 16, 12, c.mt);
    put_text(h, 28, 6, c.ui);
    put_text(h, 34, 6, c.gi);
    put_text(h, 40, 8, c.md);
    put_text(h, 48, 10, c.sz);
    h[58] = MAGIC_FIRST;
    h[59] = MAGIC_SECOND;
    if (c.ovr_pos >= 0) h[c.ovr_pos] = c.ovr_val;
  endfunction

  // digits of the given radix, sometimes short, sometimes with one stray byte
  function automatic void fill_num(inout hdr_bytes_t h, input int at, input int width,
                                   input int radix);
    int nd, k;
    nd = ($urandom_range(3) == 0) ? width : int'($urandom_range(width));
    for (k = 0; k < width; k++)
      h[at + k] = (k < nd) ? CH_ZERO + 8'($urandom_range(radix - 1)) : CH_SPACE;
    if ($urandom_range(99) < 15) h[at + int'($urandom_range(width - 1))] = 8'($urandom);
  endfunction

  function automatic logic [7:0] name_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_SPACE || c == CH_SLASH);
    return c;
  endfunction

  function automatic void make_header(output hdr_bytes_t h, input bit long_name);
    int nd, nl, k, sel;
    foreach (h[k]) h[k] = CH_SPACE;
    if (!long_name && $urandom_range(99) < 35) begin
      h[0] = CH_HASH;
      h[1] = CH_ONE;
      h[2] = CH_SLASH;
      nd = ($urandom_range(9) == 0) ? int'($urandom_range(6, 13)) : int'($urandom_range(5));
      for (k = 0; k < nd; k++) h[3 + k] = CH_ZERO + 8'($urandom_range(9));
      if ($urandom_range(9) == 0) h[$urandom_range(2)] = 8'($urandom);
    end else begin
      nl = long_name ? 16 : int'($urandom_range(16));
      for (k = 0; k < 16; k++) h[k] = (k < nl) ? name_byte() : 8'($urandom);
      if (nl < 16) begin
        sel = $urandom_range(2);
        h[nl] = (sel == 0) ? CH_SPACE : (sel == 1) ? CH_SLASH : CH_NUL;
      end
    end
    fill_num(h, 16, 12, 10);
    fill_num(h, 28, 6, 10);
    fill_num(h, 34, 6, 10);
    fill_num(h, 40, 8, 8);
    fill_num(h, 48, 10, 10);
    h[58] = MAGIC_FIRST;
    h[59] = MAGIC_SECOND;
    if ($urandom_range(19) == 0) h[58 + int'($urandom_range(1))] = 8'($urandom);
  endfunction

  function automatic void cmp_field(input string f, input logic [63:0] want,
                                    input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", f, want, got);
      errs++;
    end
  endfunction

  function automatic void check_result();
    item_t w;
    if (pending.size() == 0) begin
      $error("item with nothing expected: kind %0d last %0d", m_axis_tuser, m_axis_tlast);
      errs++;
      return;
    end
    w = pending.pop_front();
    cmp_field("item_kind", 64'(w.item_kind), 64'(m_axis_tuser));
    cmp_field("status", 64'(w.status), 64'(m_axis_tdata[1:0]));
    cmp_field("mod_time", 64'(w.mod_time), 64'(m_axis_tdata[41:2]));
    cmp_field("owner_id", 64'(w.owner_id), 64'(m_axis_tdata[61:42]));
    cmp_field("group_id", 64'(w.group_id), 64'(m_axis_tdata[81:62]));
    cmp_field("file_mode", 64'(w.file_mode), 64'(m_axis_tdata[105:82]));
    cmp_field("data_size", 64'(w.data_size), 64'(m_axis_tdata[139:106]));
    cmp_field("pad_byte", 64'(w.pad_byte), 64'(m_axis_tdata[140]));
    cmp_field("extended_name", 64'(w.extended_name), 64'(m_axis_tdata[141]));
    cmp_field("name_length", 64'(w.name_length), 64'(m_axis_tdata[157:142]));
    cmp_field("name_char", 64'(w.name_char), 64'(m_axis_tdata[165:158]));
    cmp_field("last", 64'(w.last), 64'(m_axis_tlast));
  endfunction

  // result side: check, then pick tready for the next edge
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_result();
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_gaps || ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_byte(input logic hs, input logic [7:0] b, output int n);
    if (!no_gaps && $urandom_range(99) < 37) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= hs;
    s_axis_tdata <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    n = parse_byte(hs, b);
  endtask

  task automatic send_header(input hdr_bytes_t h, input int cnt, input logic hs,
                             input logic typed, input item_t want);
    int k, n;
    for (k = 0; k < cnt; k++) begin
      send_byte((k == 0) ? hs : 1'b0, h[k], n);
      // replace the parsed summary with the one written in the table
      if (typed && n != 0) begin
        repeat (n) void'(pending.pop_back());
        pending.push_back(want);
      end
    end
  endtask

  // hold the input until every result is out, then let the block settle
  task automatic write_limit(input logic [15:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    name_limit = v;
  endtask

  initial begin : stimulus
    hdr_bytes_t hb;
    int ci, rnd, r, n, k, len;
    logic hs;
    logic [15:0] lim;

    clear_parse();
    name_limit = MAX_NAME_RST;

    cases[0] = '{-1, 1'b1, 10, "cut", "111", "222", "333", "644", "10", -1, '0, 1'b0, '0};
    cases[1] = '{-1, 1'b1, 60, "#1/0", "999999999999", "999999", "999999", "77777777",
                 "9999999999", -1, '0, 1'b1,
                 summary_of(ST_OK, 40'd999999999999, 20'd999999, 20'd999999, 24'hFFFFFF,
                            34'd9999999999, 1'b1, 1'b1, '0)};
    cases[2] = '{-1, 1'b1, 60, "x", "1", "2", "3", "4", "5", 59, 8'h0B, 1'b1,
                 summary_of(ST_BAD_MAGIC, '0, '0, '0, '0, '0, 1'b0, 1'b0, '0)};
    cases[3] = '{-1, 1'b1, 60, "#1/1025", "7", "8", "9", "600", "2000", -1, '0, 1'b1,
                 summary_of(ST_NAME_LONG, '0, '0, '0, '0, '0, 1'b0, 1'b0, '0)};
    cases[4] = '{-1, 1'b1, 60, "#1/100", "5", "1", "2", "644", "99", -1, '0, 1'b1,
                 summary_of(ST_NAME_SIZE, 40'd5, 20'd1, 20'd2, 24'o100644, '0, 1'b1, 1'b1,
                            16'd100)};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (ci = 0; ci < NCASES; ci++) begin
      if (cases[ci].limit >= 0) write_limit(16'(cases[ci].limit));
      text_header(cases[ci], hb);
      send_header(hb, cases[ci].cut, cases[ci].hs, cases[ci].typed, cases[ci].want);
    end

    rnd = 0;
    while (rnd < 3) begin
      if (rnd != 1) begin
        lim = (rnd == 0) ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 300));
        write_limit(lim);
      end
      // stall the result side while full-length short names keep coming
      if (rnd == 0) begin
        hold_reqs++;
        no_gaps = 1'b1;
      end
      if (rnd == 2) no_gaps = 1'b0;
      hs = (hpos != 6'd0) || ($urandom_range(1) == 1);
      make_header(hb, rnd < 2);
      r = (rnd < 2) ? 99 : int'($urandom_range(99));
      if (r < 8) begin
        len = $urandom_range(1, 70);
        for (k = 0; k < len; k++) send_byte($urandom_range(99) < 4, 8'($urandom), n);
      end else if (r < 16) begin
        send_header(hb, $urandom_range(1, 59), hs, 1'b0, '0);
      end else begin
        send_header(hb, 60, hs, 1'b0, '0);
      end
      rnd++;
    end

    s_axis_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errs == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/arhdr_pkg.sv
sv/arhdr_ram.sv
sv/arhdr_parse.sv
sv/arhdr_emit.sv
sv/ar_archive_header_parser_core.sv
test/tb.sv
